FILE: hw/rtl/dkq_pkg.sv
// Package: shared constants and record types for the descending-key quicksort.
`timescale 1ns / 1ps
package dkq_pkg;
    localparam int MAX_RECORDS = 64;
    localparam int KEY_WIDTH   = 16;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int STK_W       = 2 * ADDR_W;

    typedef struct packed {
        logic [15:0] sort_key;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_key;
        logic [5:0]  original_index;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [ADDR_W-1:0]    idx;
    } t_rec;

    localparam int REC_W = $bits(t_rec);
endpackage

FILE: hw/rtl/dkq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dkq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/descending_key_quicksort.sv
// Top level: record memory, range stack and quicksort sequencer.
// Loading: one record per cycle, busy stays low until the record marked last.
// Sort: each partition scan step is a read plus a compare (S_RRD/S_RCMP or S_LRD/S_LCMP).
// Output: each result takes a read state and an emit state after the sort; the receiver cannot stall.
// Reset: synchronous active-low; clears counters and sequencer, memories are not cleared.
`timescale 1ns / 1ps
module descending_key_quicksort (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  dkq_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_result_valid,
    output dkq_pkg::t_out_item  o_result
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_POP   = 13'b0000000000010,
        S_POPD  = 13'b0000000000100,
        S_PIVR  = 13'b0000000001000,
        S_PIVD  = 13'b0000000010000,
        S_RRD   = 13'b0000000100000,
        S_RCMP  = 13'b0000001000000,
        S_LRD   = 13'b0000010000000,
        S_LCMP  = 13'b0000100000000,
        S_DONE  = 13'b0001000000000,
        S_PUSH2 = 13'b0010000000000,
        S_ORD   = 13'b0100000000000,
        S_OEM   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [dkq_pkg::CNT_W-1:0]  r_cnt, n_cnt, r_sp, n_sp, r_k, n_k;
    logic [dkq_pkg::ADDR_W-1:0] r_lo, n_lo, r_hi, n_hi, r_piv, n_piv;
    logic [dkq_pkg::ADDR_W-1:0] r_first, n_first, r_last, n_last;
    dkq_pkg::t_rec              r_pivot, n_pivot;

    logic                       mem_we, stk_we;
    logic [dkq_pkg::ADDR_W-1:0] mem_waddr, mem_raddr, stk_waddr, stk_raddr;
    dkq_pkg::t_rec              mem_wdata, mem_rdata;
    logic [dkq_pkg::STK_W-1:0]  stk_wdata, stk_rdata;
    logic                       push1_ok, push2_ok, sp_room;
    logic [dkq_pkg::CNT_W-1:0]  cnt_next, sp_dec;

    dkq_ram #(.WIDTH(dkq_pkg::REC_W), .DEPTH(dkq_pkg::MAX_RECORDS)) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    dkq_ram #(.WIDTH(dkq_pkg::STK_W), .DEPTH(dkq_pkg::MAX_RECORDS)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    assign sp_room  = r_sp < dkq_pkg::CNT_W'(dkq_pkg::MAX_RECORDS);
    assign push1_ok = ({1'b0, r_piv} + 1'b1) < {1'b0, r_last};
    assign push2_ok = {1'b0, r_piv} > ({1'b0, r_first} + 1'b1);
    assign sp_dec   = r_sp - 1'b1;
    assign cnt_next = r_cnt + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_sp      = r_sp;
        n_k       = r_k;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_piv     = r_piv;
        n_first   = r_first;
        n_last    = r_last;
        n_pivot   = r_pivot;
        mem_we    = 1'b0;
        mem_waddr = r_piv;
        mem_wdata = mem_rdata;
        mem_raddr = r_lo;
        stk_we    = 1'b0;
        stk_waddr = r_sp[dkq_pkg::ADDR_W-1:0];
        stk_wdata = {r_piv + 1'b1, r_last};
        stk_raddr = sp_dec[dkq_pkg::ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    mem_waddr = r_cnt[dkq_pkg::ADDR_W-1:0];
                    mem_wdata.key = i_item.sort_key[dkq_pkg::KEY_WIDTH-1:0];
                    mem_wdata.idx = r_cnt[dkq_pkg::ADDR_W-1:0];
                    if (r_cnt < dkq_pkg::CNT_W'(dkq_pkg::MAX_RECORDS)) begin
                        mem_we = 1'b1;
                        n_cnt  = cnt_next;
                    end
                    if (i_item.last_item) begin
                        // whole set is the first range; no stack entry needed
                        n_lo    = '0;
                        n_first = '0;
                        n_hi    = n_cnt[dkq_pkg::ADDR_W-1:0] - 1'b1;
                        n_last  = n_cnt[dkq_pkg::ADDR_W-1:0] - 1'b1;
                        n_k     = '0;
                        n_state = (n_cnt >= dkq_pkg::CNT_W'(2)) ? S_PIVR : S_ORD;
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_sp    = sp_dec;
                    n_state = S_POPD;
                end
            end
            S_POPD: begin
                n_lo    = stk_rdata[dkq_pkg::STK_W-1:dkq_pkg::ADDR_W];
                n_first = stk_rdata[dkq_pkg::STK_W-1:dkq_pkg::ADDR_W];
                n_hi    = stk_rdata[dkq_pkg::ADDR_W-1:0];
                n_last  = stk_rdata[dkq_pkg::ADDR_W-1:0];
                n_state = (n_first >= n_last) ? S_POP : S_PIVR;
            end
            S_PIVR: begin
                mem_raddr = r_lo;
                n_piv     = r_lo;
                n_state   = S_PIVD;
            end
            S_PIVD: begin
                n_pivot = mem_rdata;
                n_state = S_RRD;
            end
            S_RRD: begin
                mem_raddr = r_hi;
                n_state   = (r_hi == r_piv) ? S_DONE : S_RCMP;
            end
            S_RCMP: begin
                if (r_pivot.key >= mem_rdata.key) begin
                    n_hi    = r_hi - 1'b1;
                    n_state = S_RRD;
                end else begin
                    // pivot slot takes the larger key; pivot itself is held in r_pivot
                    mem_we  = 1'b1;
                    n_piv   = r_hi;
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                mem_raddr = r_lo;
                n_state   = (r_lo == r_piv) ? S_DONE : S_LCMP;
            end
            S_LCMP: begin
                if (mem_rdata.key >= r_pivot.key) begin
                    n_lo    = r_lo + 1'b1;
                    n_state = S_LRD;
                end else begin
                    mem_we  = 1'b1;
                    n_piv   = r_lo;
                    n_state = S_RRD;
                end
            end
            S_DONE: begin
                mem_we    = 1'b1;
                mem_wdata = r_pivot;
                if (push1_ok && sp_room) begin
                    stk_we = 1'b1;
                    n_sp   = r_sp + 1'b1;
                end
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                stk_wdata = {r_first, r_piv - 1'b1};
                if (push2_ok && sp_room) begin
                    stk_we = 1'b1;
                    n_sp   = r_sp + 1'b1;
                end
                n_state = S_POP;
            end
            S_ORD: begin
                mem_raddr = r_k[dkq_pkg::ADDR_W-1:0];
                n_state   = S_OEM;
            end
            S_OEM: begin
                n_k = r_k + 1'b1;
                if (n_k == r_cnt) begin
                    n_cnt   = '0;
                    n_sp    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ORD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sp    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sp    <= n_sp;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_piv   <= n_piv;
        r_first <= n_first;
        r_last  <= n_last;
        r_pivot <= n_pivot;
    end

    assign busy                    = r_state != S_IDLE;
    assign o_result_valid          = r_state == S_OEM;
    assign o_result.out_key        = 16'(mem_rdata.key);
    assign o_result.original_index = 6'(mem_rdata.idx);
    assign o_result.last_result    = (r_k + 1'b1) == r_cnt;

`ifndef NO_ASSERTIONS
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");
    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_result) |=> !busy)
        else $error("block not idle after final result");
    a_no_strobe_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_result) |=> !o_result_valid)
        else $error("result after final record");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= dkq_pkg::CNT_W'(dkq_pkg::MAX_RECORDS))
        else $error("range stack overflow");
`endif
endmodule
